// ===== rtl/tte_pkg.sv =====
// Shared constants and types for the triggered table envelope unit.
`default_nettype none
package tte_pkg;

    localparam int TS_W      = 10;
    localparam int DUR_W     = 24;
    localparam int ADDR_W    = 10;
    localparam int VAL_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_FROM_ITEM  = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [TS_W-1:0]  TS_RESET  = 10'd1023;
    localparam logic [DUR_W-1:0] DUR_RESET = 24'd48000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

// ===== rtl/tte_div.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
`default_nettype none
module tte_div #(
    parameter int QW = 26
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [QW-1:0]            dividend,
    input  wire logic [tte_pkg::DUR_W-1:0] divisor,
    output logic      [QW-1:0]            quotient,
    output tte_pkg::div_status_t          status
);

    localparam int CW = $clog2(QW);

    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [tte_pkg::DUR_W-1:0]  rem_reg;
    logic [tte_pkg::DUR_W-1:0]  dsr_reg;
    logic [QW-1:0]              dvd_reg;
    logic [tte_pkg::DUR_W:0]    trial;
    logic [tte_pkg::DUR_W:0]    diff;
    logic                       take;
    logic [tte_pkg::DUR_W-1:0]  rem_next;

    always_comb begin
        trial    = {rem_reg, dvd_reg[QW-1]};
        diff     = trial - {1'b0, dsr_reg};
        take     = trial >= {1'b0, dsr_reg};
        rem_next = take ? diff[tte_pkg::DUR_W-1:0] : trial[tte_pkg::DUR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(QW - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= (divisor == '0) ? tte_pkg::DUR_W'(1) : divisor;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[QW-2:0], take};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign quotient    = dvd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/triggered_table_envelope_unit.sv =====
// Top level of the triggered table envelope unit: sequencer, envelope memory and output register.
// A table write beat is taken in ST_IDLE and starts no result. A sample beat from an idle player
// passes ST_READ0 and ST_EMIT to the output register, a playing one ST_READ0, ST_READ1, ST_MUL,
// ST_FIN and ST_EMIT (two memory reads, one multiply, one finish step). ST_EMIT waits for a free
// output register. A trigger first runs the serial step divide in ST_DIV. New beats are accepted
// only in ST_IDLE. Synchronous active-low reset.
`default_nettype none
module triggered_table_envelope_unit #(
    parameter int TABLE_DEPTH   = 1024,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [tte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tte_pkg::DUR_W-1:0]          cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_opcode,
    input  wire logic                               s_trigger,
    input  wire logic [tte_pkg::DUR_W-1:0]          s_item_duration,
    input  wire logic [tte_pkg::ADDR_W-1:0]         s_table_address,
    input  wire logic signed [tte_pkg::VAL_W-1:0]   s_table_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [tte_pkg::VAL_W-1:0]        m_sample_out,
    output logic                                    m_playing
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int QW    = tte_pkg::TS_W + FRACTION_BITS;
    localparam int POS_W = QW + 1;
    localparam int IPW   = tte_pkg::TS_W + 1;
    localparam int CMPW  = (AW > IPW + 1) ? AW : IPW + 1;
    localparam int PW    = tte_pkg::VAL_W + 2 + FRACTION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ0,
        ST_READ1,
        ST_MUL,
        ST_FIN,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [tte_pkg::TS_W-1:0]  table_size_reg;
    logic [tte_pkg::DUR_W-1:0] fixed_duration_reg;
    logic                      dur_from_item_reg;

    logic [POS_W-1:0]          pos_reg;
    logic [QW-1:0]             step_reg;
    logic                      running_reg;

    logic [tte_pkg::VAL_W-1:0] envelope_mem [TABLE_DEPTH];
    logic [tte_pkg::VAL_W-1:0] rd_data_reg;
    logic signed [tte_pkg::VAL_W-1:0] x0_reg;
    logic signed [PW-1:0]      prod_reg;
    logic signed [tte_pkg::VAL_W-1:0] res_sample_reg;
    logic                      res_playing_reg;
    logic                      m_valid_reg;
    logic signed [tte_pkg::VAL_W-1:0] m_sample_reg;
    logic                      m_playing_reg;

    logic                      accept;
    logic                      accept_write;
    logic                      div_start;
    logic [tte_pkg::DUR_W-1:0] div_divisor;
    logic [QW-1:0]             div_quotient;
    tte_pkg::div_status_t      div_st;

    logic [IPW-1:0]            ip;
    logic [IPW:0]              ip_sel;
    logic [IPW:0]              ip_cap;
    logic [CMPW-1:0]           ip_ext;
    logic [CMPW-1:0]           addr_cap;
    logic [AW-1:0]             rd_addr;
    logic [CMPW-1:0]           wr_ext;
    logic                      wr_ok;
    logic signed [tte_pkg::VAL_W:0] diff;
    logic signed [FRACTION_BITS:0]  frac_s;
    logic signed [PW-1:0]      prod_next;
    logic signed [PW-1:0]      y_sum;
    logic [POS_W-1:0]          pos_next;
    logic [POS_W-1:0]          pos_limit;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign accept_write = accept && (s_opcode == tte_pkg::OP_WRITE);
    assign div_start    = accept && (s_opcode == tte_pkg::OP_TICK) && s_trigger;
    assign div_divisor  = dur_from_item_reg ? s_item_duration : fixed_duration_reg;

    tte_div #(
        .QW(QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({table_size_reg, {FRACTION_BITS{1'b0}}}),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_st)
    );

    always_comb begin
        ip       = pos_reg[POS_W-1:FRACTION_BITS];
        ip_sel   = (state_reg == ST_READ1) ? ({1'b0, ip} + (IPW+1)'(1)) : {1'b0, ip};
        ip_cap   = (ip_sel > (IPW+1)'(table_size_reg)) ? (IPW+1)'(table_size_reg) : ip_sel;
        ip_ext   = CMPW'(ip_cap);
        addr_cap = (ip_ext > CMPW'(TABLE_DEPTH - 1)) ? CMPW'(TABLE_DEPTH - 1) : ip_ext;
        rd_addr  = addr_cap[AW-1:0];
        wr_ext   = CMPW'(s_table_address);
        wr_ok    = wr_ext <= CMPW'(TABLE_DEPTH - 1);
    end

    always_comb begin
        diff      = (tte_pkg::VAL_W+1)'(signed'(rd_data_reg)) - (tte_pkg::VAL_W+1)'(x0_reg);
        frac_s    = signed'({1'b0, pos_reg[FRACTION_BITS-1:0]});
        prod_next = diff * frac_s;
        y_sum     = (prod_reg >>> FRACTION_BITS) + PW'(x0_reg);
        pos_next  = pos_reg + POS_W'(step_reg);
        pos_limit = POS_W'({table_size_reg, {FRACTION_BITS{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (accept_write && wr_ok) begin
            envelope_mem[wr_ext[AW-1:0]] <= s_table_value;
        end
        rd_data_reg <= envelope_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg     <= tte_pkg::TS_RESET;
            fixed_duration_reg <= tte_pkg::DUR_RESET;
            dur_from_item_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tte_pkg::CFG_TABLE_SIZE: begin
                    table_size_reg <= cfg_wdata[tte_pkg::TS_W-1:0];
                end
                tte_pkg::CFG_FIXED_DURATION: begin
                    fixed_duration_reg <= cfg_wdata;
                end
                tte_pkg::CFG_DUR_FROM_ITEM: begin
                    dur_from_item_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            step_reg    <= '0;
            running_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept && (s_opcode == tte_pkg::OP_TICK)) begin
                        state_reg <= s_trigger ? ST_DIV : ST_READ0;
                    end
                end
                ST_DIV: begin
                    if (div_st.done) begin
                        step_reg    <= div_quotient;
                        pos_reg     <= '0;
                        running_reg <= 1'b1;
                        state_reg   <= ST_READ0;
                    end
                end
                ST_READ0: begin
                    if (running_reg) begin
                        state_reg <= ST_READ1;
                    end else begin
                        res_sample_reg  <= '0;
                        res_playing_reg <= 1'b0;
                        state_reg       <= ST_EMIT;
                    end
                end
                ST_READ1: begin
                    x0_reg    <= signed'(rd_data_reg);
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= prod_next;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    res_sample_reg  <= y_sum[tte_pkg::VAL_W-1:0];
                    res_playing_reg <= 1'b1;
                    pos_reg         <= pos_next;
                    if (pos_next > pos_limit) begin
                        running_reg <= 1'b0;
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_sample_reg  <= res_sample_reg;
                        m_playing_reg <= res_playing_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_reg;
    assign m_playing    = m_playing_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("Divider finished outside the divide state.");

    a_idle_output_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_playing) |-> (m_sample_out == '0))
        else $error("A sample beat from an idle player is not zero.");

    a_write_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == tte_pkg::OP_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("A table write beat started a result.");

    a_trigger_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> div_st.busy)
        else $error("A trigger beat did not start the divider.");
`endif

endmodule
`default_nettype wire
